// ----- rtl/core/sha256_pkg.sv -----
// SHA-256 engine package: round constants, initial hash values, controller
// states and the command/status structs between controller and datapath.
// No dependencies.
package sha256_pkg;

  localparam int unsigned RoundCount = 64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPRESS,
    ST_PAD,
    ST_EMIT
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       put_byte;     // write put_data at the fill position
    logic [7:0] put_data;
    logic       count_byte;   // advance the message length
    logic       put_length;   // write the bit length into words 14 and 15
    logic       start_comp;   // load working variables, clear round counter
    logic       round_step;   // run one round
    logic       fold_hash;    // add working variables into the hash words
    logic       reset_msg;    // back to initial hash, zero length and fill
  } sha_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [5:0] fill;
    logic       last_round;
  } sha_stat_t;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ----- rtl/core/sha256_datapath.sv -----
// SHA-256 datapath: block buffer, rolling message schedule, working
// variables, hash words and length counter. Uses sha256_pkg.
module sha256_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  sha256_pkg::sha_cmd_t cmd,
  output sha256_pkg::sha_stat_t stat,
  input  logic [2:0]          hash_sel,
  output logic [31:0]         hash_word
);

  logic [31:0] blk_r [16];
  logic [31:0] hash_r [8];
  logic [31:0] var_r [8];
  logic [5:0]  fill_r;
  logic [5:0]  round_r;
  logic [60:0] total_r;

  logic [31:0] s0, s1, w_new, w_cur, t1, t2, e, a;
  logic [31:0] a_nxt, e_nxt;
  logic [63:0] bits;
  logic [3:0]  widx;
  logic [1:0]  bpos;

  assign stat.fill       = fill_r;
  assign stat.last_round = (round_r == 6'(sha256_pkg::RoundCount - 1));
  assign hash_word       = hash_r[hash_sel];
  assign bits            = {total_r, 3'b000};
  assign widx            = fill_r[5:2];
  assign bpos            = fill_r[1:0];

  // Round logic; the block buffer doubles as the 16-word schedule window.
  always_comb begin
    w_cur = blk_r[0];
    s0 = sha256_pkg::rotr(blk_r[1], 7) ^ sha256_pkg::rotr(blk_r[1], 18) ^ (blk_r[1] >> 3);
    s1 = sha256_pkg::rotr(blk_r[14], 17) ^ sha256_pkg::rotr(blk_r[14], 19)
         ^ (blk_r[14] >> 10);
    w_new = blk_r[0] + s0 + blk_r[9] + s1;
    e = var_r[4];
    a = var_r[0];
    t1 = var_r[7] + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11) ^ sha256_pkg::rotr(e, 25))
         + ((e & var_r[5]) ^ (~e & var_r[6])) + sha256_pkg::round_k(round_r) + w_cur;
    t2 = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
         + ((a & var_r[1]) ^ (a & var_r[2]) ^ (var_r[1] & var_r[2]));
    a_nxt = t1 + t2;
    e_nxt = var_r[3] + t1;
  end

  // Block buffer: byte writes, length words and schedule shifting.
  always_ff @(posedge clk) begin
    if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) blk_r[i] <= blk_r[i + 1];
      blk_r[15] <= w_new;
    end else begin
      if (cmd.put_byte) begin
        unique case (bpos)
          2'd0: blk_r[widx][31:24] <= cmd.put_data;
          2'd1: blk_r[widx][23:16] <= cmd.put_data;
          2'd2: blk_r[widx][15:8]  <= cmd.put_data;
          2'd3: blk_r[widx][7:0]   <= cmd.put_data;
          default: ;
        endcase
      end
      if (cmd.put_length) begin
        blk_r[14] <= bits[63:32];
        blk_r[15] <= bits[31:0];
      end
    end
  end

  // Working variables.
  always_ff @(posedge clk) begin
    if (cmd.start_comp) begin
      for (int i = 0; i < 8; i++) var_r[i] <= hash_r[i];
    end else if (cmd.round_step) begin
      var_r[7] <= var_r[6];
      var_r[6] <= var_r[5];
      var_r[5] <= var_r[4];
      var_r[4] <= e_nxt;
      var_r[3] <= var_r[2];
      var_r[2] <= var_r[1];
      var_r[1] <= var_r[0];
      var_r[0] <= a_nxt;
    end
  end

  // Control registers: hash words, fill position, round counter, length.
  // The fold happens with the last round, so it adds that round's results.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.reset_msg) begin
      for (int i = 0; i < 8; i++) hash_r[i] <= sha256_pkg::InitHash[i];
      fill_r  <= '0;
      total_r <= '0;
      round_r <= '0;
    end else begin
      if (cmd.fold_hash) begin
        hash_r[0] <= hash_r[0] + a_nxt;
        hash_r[1] <= hash_r[1] + var_r[0];
        hash_r[2] <= hash_r[2] + var_r[1];
        hash_r[3] <= hash_r[3] + var_r[2];
        hash_r[4] <= hash_r[4] + e_nxt;
        hash_r[5] <= hash_r[5] + var_r[4];
        hash_r[6] <= hash_r[6] + var_r[5];
        hash_r[7] <= hash_r[7] + var_r[6];
      end
      if (cmd.put_byte) fill_r <= fill_r + 6'd1;
      if (cmd.count_byte) total_r <= total_r + 61'd1;
      if (cmd.start_comp) round_r <= '0;
      else if (cmd.round_step) round_r <= round_r + 6'd1;
    end
  end

endmodule

// ----- rtl/core/sha256_ctrl.sv -----
// SHA-256 controller: sequences byte intake, padding, compressions and
// digest output. Uses sha256_pkg.
module sha256_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_byte,
  input  logic                 in_present,
  input  logic                 in_last,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [2:0]           word_sel,
  output sha256_pkg::sha_cmd_t cmd,
  input  sha256_pkg::sha_stat_t stat
);

  sha256_pkg::ctrl_state_t state_r, state_nxt;
  logic       final_r, final_nxt;   // message closed, padding underway
  logic       len_r, len_nxt;       // length written, next compression is last
  logic       mark_r, mark_nxt;     // 0x80 still to be placed
  logic [2:0] word_r, word_nxt;
  logic       running, acc;

  assign in_tready  = (state_r == sha256_pkg::ST_IDLE);
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = (state_r == sha256_pkg::ST_EMIT);
  assign word_sel   = word_r;
  assign running    = (state_r == sha256_pkg::ST_COMPRESS);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    final_nxt = final_r;
    len_nxt   = len_r;
    mark_nxt  = mark_r;
    word_nxt  = word_r;
    unique case (state_r)
      sha256_pkg::ST_IDLE: begin
        if (acc) begin
          if (in_present && stat.fill == 6'd63) begin
            state_nxt = sha256_pkg::ST_COMPRESS;
            final_nxt = in_last;
            mark_nxt  = in_last;
          end else if (in_last) begin
            state_nxt = sha256_pkg::ST_PAD;
            final_nxt = 1'b1;
            mark_nxt  = 1'b1;
          end
        end
      end
      sha256_pkg::ST_COMPRESS: begin
        if (cmd.round_step && stat.last_round) begin
          if (!final_r) state_nxt = sha256_pkg::ST_IDLE;
          else if (len_r) begin
            state_nxt = sha256_pkg::ST_EMIT;
            word_nxt  = '0;
          end else state_nxt = sha256_pkg::ST_PAD;
        end
      end
      sha256_pkg::ST_PAD: begin
        mark_nxt = 1'b0;
        if (stat.fill == 6'd55) len_nxt = 1'b1;
        if (stat.fill == 6'd55 || stat.fill == 6'd63)
          state_nxt = sha256_pkg::ST_COMPRESS;
      end
      sha256_pkg::ST_EMIT: begin
        if (out_tready) begin
          word_nxt = word_r + 3'd1;
          if (word_r == 3'd7) begin
            state_nxt = sha256_pkg::ST_IDLE;
            final_nxt = 1'b0;
            len_nxt   = 1'b0;
          end
        end
      end
      default: state_nxt = sha256_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd = '0;
    unique case (state_r)
      sha256_pkg::ST_IDLE: begin
        cmd.put_byte   = acc && in_present;
        cmd.count_byte = acc && in_present;
        cmd.put_data   = in_byte;
        cmd.start_comp = acc && in_present && stat.fill == 6'd63;
      end
      sha256_pkg::ST_COMPRESS: begin
        cmd.round_step = 1'b1;
      end
      sha256_pkg::ST_PAD: begin
        // Fill position 56 after padding means the length goes in now.
        cmd.put_byte   = 1'b1;
        cmd.put_data   = mark_r ? 8'h80 : 8'h00;
        cmd.start_comp = (stat.fill == 6'd55 || stat.fill == 6'd63);
      end
      sha256_pkg::ST_EMIT: begin
        cmd.reset_msg = out_tready && word_r == 3'd7;
      end
      default: ;
    endcase
    // Length goes in once the fill reaches 56; compressing then ends the message.
    if (state_r == sha256_pkg::ST_PAD && stat.fill == 6'd55) cmd.put_length = 1'b1;
    cmd.fold_hash = running && stat.last_round;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha256_pkg::ST_IDLE;
      final_r <= 1'b0;
      len_r   <= 1'b0;
      mark_r  <= 1'b0;
      word_r  <= '0;
    end else begin
      state_r <= state_nxt;
      final_r <= final_nxt;
      len_r   <= len_nxt;
      mark_r  <= mark_nxt;
      word_r  <= word_nxt;
    end
  end

endmodule

// ----- rtl/core/sha256_hash_engine.sv -----
// SHA-256 engine top level: joins the controller and the datapath.
// Depends on sha256_pkg, sha256_ctrl and sha256_datapath.
//
// A byte request is taken only while the engine is idle. A request that
// completes a 64-byte block also loads the working variables in its own
// cycle; the rounds of the one round unit follow, during which no request is
// taken. A request that closes the message is followed by the padding bytes
// (the last of them loads the working variables) and the rounds of each of the
// one or two compressions, then eight digest-word requests at one per cycle as
// the sink accepts them. No request is taken until the eighth word has gone.
module sha256_hash_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // message_byte
  input  logic        in_tuser,   // byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // digest_word[31:0], word_index[34:32], zero fill
  output logic        out_tlast   // last_word
);

  sha256_pkg::sha_cmd_t  cmd;
  sha256_pkg::sha_stat_t stat;
  logic [2:0]  word_sel;
  logic [31:0] hash_word;

  sha256_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready,
    .in_byte(in_tdata), .in_present(in_tuser), .in_last(in_tlast),
    .out_tvalid, .out_tready, .word_sel, .cmd, .stat
  );

  sha256_datapath u_dp (
    .clk, .rst_n, .cmd, .stat, .hash_sel(word_sel), .hash_word
  );

  assign out_tdata = {5'd0, word_sel, hash_word};
  assign out_tlast = (word_sel == 3'd7);

  // No input is taken while a digest is waiting.
  a_no_in_during_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken during digest output");

  // Word index advances only on an accepted digest word.
  a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(word_sel)))
    else $error("digest word index moved while stalled");

endmodule
